@@ src/trk_pkg.sv @@
// shared types, codes and helpers for the can id tracking table
package trk_pkg;

  localparam logic [3:0] MAX_LEN = 4'd8;

  typedef enum logic [1:0] {
    ACT_HIT     = 2'd0,
    ACT_NEW     = 2'd1,
    ACT_REPLACE = 2'd2
  } trk_action_t;

  // search packet handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [28:0] id;
    logic [31:0] bound;
  } trk_probe_t;

  // write broadcast to all cells
  typedef struct packed {
    logic        en;
    logic        new_id;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] mask;
    logic [63:0] data;
    logic [31:0] now;
  } trk_wr_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [5:0] sh;
    sh = {len[2:0], 3'b000};
    if (len >= MAX_LEN) begin
      return '1;
    end
    return (64'd1 << sh) - 64'd1;
  endfunction

endpackage

@@ src/trk_in_if.sv @@
// frame input channel
interface trk_in_if
  import trk_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [28:0] can_id;
  logic        is_extended;
  logic [3:0]  byte_count;
  logic [63:0] payload;
  logic [31:0] now_ms;

  modport source (output valid, can_id, is_extended, byte_count, payload, now_ms,
                  input ready);
  modport sink (input valid, can_id, is_extended, byte_count, payload, now_ms,
                output ready);
endinterface

@@ src/trk_out_if.sv @@
// result output channel
interface trk_out_if
  import trk_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [2:0]  slot;
  logic [1:0]  action;
  logic [3:0]  occupied;
  logic [31:0] frame_total;

  modport source (output valid, slot, action, occupied, frame_total, input ready);
  modport sink (input valid, slot, action, occupied, frame_total, output ready);
endinterface

@@ src/can_id_tracking_table_unit.sv @@
// top level: frame capture, search chain of entry cells, update and result
//
//   channel | dir | beat contents
//   rx      | in  | can_id, is_extended, byte_count, payload, now_ms
//   res     | out | slot, action, occupied, frame_total
//
// a frame goes from accept through the launch, the registered stage of each cell
// along the search chain, then decide, write and emit into the result register.
// rx takes a new beat only once the previous result is registered, even while
// res is stalled; the next result then waits in emit.
// synchronous reset clears the whole table.
module can_id_tracking_table_unit
  import trk_pkg::*;
#(
  parameter int ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst,
  trk_in_if.sink    rx,
  trk_out_if.source res
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_EMIT} state_t;

  state_t      state;
  logic        launch;
  logic [28:0] cap_id;
  logic        cap_ext;
  logic [3:0]  cap_len;
  logic [63:0] cap_data;
  logic [31:0] cap_now;
  logic [IW-1:0] k;
  trk_action_t act;
  logic [CW-1:0] used_count;
  logic [31:0] frame_counter;

  trk_probe_t    probe   [ENTRIES+1];
  logic [IW-1:0] hit_idx [ENTRIES+1];
  logic [IW-1:0] min_idx [ENTRIES+1];
  logic [ENTRIES:0] chain_valid;
  trk_wr_t       wr;
  logic [IW+2:0] k_wide;
  logic [CW+3:0] used_wide;

  assign rx.ready = (state == ST_IDLE);

  assign probe[0].valid = launch;
  assign probe[0].hit   = 1'b0;
  assign probe[0].id    = cap_id;
  assign probe[0].bound = cap_now;
  assign hit_idx[0]     = '0;
  assign min_idx[0]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    trk_cell #(.IW(IW), .CW(CW), .INDEX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .used_count (used_count),
      .probe_in   (probe[i]),
      .hit_idx_in (hit_idx[i]),
      .min_idx_in (min_idx[i]),
      .probe_out  (probe[i+1]),
      .hit_idx_out(hit_idx[i+1]),
      .min_idx_out(min_idx[i+1]),
      .wr         (wr),
      .wr_idx     (k)
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_valid
    assign chain_valid[i] = probe[i].valid;
  end

  always_comb begin
    wr.en     = (state == ST_WRITE);
    wr.new_id = (act != ACT_HIT);
    wr.id     = cap_id;
    wr.ext    = cap_ext;
    wr.len    = cap_len;
    wr.mask   = byte_mask(cap_len);
    wr.data   = cap_data;
    wr.now    = cap_now;
    k_wide    = {3'b000, k};
    used_wide = {4'b0000, used_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      launch        <= 1'b0;
      used_count    <= '0;
      frame_counter <= '0;
      res.valid     <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (res.valid && res.ready && (state != ST_EMIT)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rx.valid) begin
            cap_id   <= rx.can_id;
            cap_ext  <= rx.is_extended;
            cap_len  <= (rx.byte_count > MAX_LEN) ? MAX_LEN : rx.byte_count;
            cap_data <= rx.payload;
            cap_now  <= rx.now_ms;
            launch   <= 1'b1;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (probe[ENTRIES].valid) begin
            if (probe[ENTRIES].hit) begin
              k   <= hit_idx[ENTRIES];
              act <= ACT_HIT;
            end else if (used_count < CW'(ENTRIES)) begin
              k   <= IW'(used_count);
              act <= ACT_NEW;
            end else begin
              k   <= min_idx[ENTRIES];
              act <= ACT_REPLACE;
            end
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (act == ACT_NEW) begin
            used_count <= used_count + CW'(1);
          end
          frame_counter <= frame_counter + 32'd1;
          state         <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid       <= 1'b1;
            res.slot        <= k_wide[2:0];
            res.action      <= act;
            res.occupied    <= used_wide[3:0];
            res.frame_total <= frame_counter;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one probe in the search chain");

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    probe[ENTRIES].valid |-> state == ST_SCAN)
    else $error("probe left the chain outside a scan");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(ENTRIES))
    else $error("occupancy above table size");

  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && act == ACT_NEW) |-> used_count < CW'(ENTRIES))
    else $error("new entry filled in a full table");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |=> frame_counter == $past(frame_counter) + 32'd1)
    else $error("frame counter did not advance on write");

endmodule

@@ src/trk_cell.sv @@
// one table entry with its stage of the search chain
module trk_cell
  import trk_pkg::*;
#(
  parameter int IW    = 3,
  parameter int CW    = 4,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CW-1:0]    used_count,
  input  trk_probe_t       probe_in,
  input  logic [IW-1:0]    hit_idx_in,
  input  logic [IW-1:0]    min_idx_in,
  output trk_probe_t       probe_out,
  output logic [IW-1:0]    hit_idx_out,
  output logic [IW-1:0]    min_idx_out,
  input  trk_wr_t          wr,
  input  logic [IW-1:0]    wr_idx
);

  logic [28:0] entry_id;
  logic        entry_extended;
  logic [3:0]  entry_length;
  logic [63:0] entry_data;
  logic [31:0] entry_last_seen;

  logic        used;
  logic        match;
  logic        older;
  trk_probe_t  probe_next;

  always_comb begin
    used  = CW'(INDEX) < used_count;
    match = probe_in.valid && used && !probe_in.hit && (entry_id == probe_in.id);
    older = entry_last_seen < probe_in.bound;
    probe_next       = probe_in;
    probe_next.hit   = probe_in.hit | match;
    probe_next.bound = older ? entry_last_seen : probe_in.bound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.hit   <= probe_next.hit;
    probe_out.id    <= probe_next.id;
    probe_out.bound <= probe_next.bound;
    hit_idx_out     <= match ? IW'(INDEX) : hit_idx_in;
    min_idx_out     <= older ? IW'(INDEX) : min_idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_id        <= '0;
      entry_extended  <= 1'b0;
      entry_length    <= '0;
      entry_data      <= '0;
      entry_last_seen <= '0;
    end else if (wr.en && (wr_idx == IW'(INDEX))) begin
      if (wr.new_id) begin
        entry_id       <= wr.id;
        entry_extended <= wr.ext;
      end
      entry_length    <= wr.len;
      entry_data      <= (entry_data & ~wr.mask) | (wr.data & wr.mask);
      entry_last_seen <= wr.now;
    end
  end

endmodule

@@ tb/can_id_tracking_table_unit_test.sv @@
// testbench for the can id tracking table unit: frame stimulus, table tracking, result compare
module can_id_tracking_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trk_pkg::*;

  localparam int TBL_DEPTH = 8;
  localparam int PIPE_DEPTH = TBL_DEPTH + 4;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    logic [31:0] now;
  } frame_t;

  typedef struct {
    logic [2:0]  slot;
    trk_action_t action;
    logic [3:0]  occupied;
    logic [31:0] total;
  } result_t;

  logic clk;
  logic rst;

  trk_in_if  rx ();
  trk_out_if res ();

  can_id_tracking_table_unit #(
    .ENTRIES(TBL_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .res(res)
  );

  frame_t  rx_frames[$];
  result_t pending_results[$];

  logic [28:0] tbl_id   [TBL_DEPTH];
  logic        tbl_ext  [TBL_DEPTH];
  logic [3:0]  tbl_len  [TBL_DEPTH];
  logic [63:0] tbl_data [TBL_DEPTH];
  logic [31:0] tbl_seen [TBL_DEPTH];
  int unsigned tbl_used;
  logic [31:0] frames_seen;

  int phase;
  int snd_idle;
  int rcv_idle;
  int err_count;
  int quiet_cycles;
  int hold_left;
  int last_phase;

  logic [28:0] id_pool [16];
  int          pool_size;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t track_frame(frame_t f);
    logic [3:0]  len;
    logic [63:0] keep;
    logic [31:0] bound;
    int          k;
    bit          hit;
    result_t     r;
    len = (f.len > MAX_LEN) ? MAX_LEN : f.len;
    keep = (len == MAX_LEN) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
    frames_seen = frames_seen + 32'd1;
    hit = 1'b0;
    k = 0;
    for (int i = 0; i < tbl_used; i++) begin
      if (!hit && tbl_id[i] == f.id) begin
        k = i;
        hit = 1'b1;
      end
    end
    if (hit) begin
      r.action = ACT_HIT;
    end else begin
      if (tbl_used < TBL_DEPTH) begin
        k = tbl_used;
        tbl_used++;
        r.action = ACT_NEW;
      end else begin
        // least recently seen, first entry wins on a tie, entry 0 if none is older
        bound = f.now;
        k = 0;
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (tbl_seen[i] < bound) begin
            bound = tbl_seen[i];
            k = i;
          end
        end
        r.action = ACT_REPLACE;
      end
      tbl_id[k] = f.id;
      tbl_ext[k] = f.ext;
    end
    tbl_len[k] = len;
    tbl_data[k] = (tbl_data[k] & ~keep) | (f.data & keep);
    tbl_seen[k] = f.now;
    r.slot = 3'(k);
    r.occupied = 4'(tbl_used);
    r.total = frames_seen;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with none pending, slot", res.slot, 0);
      return;
    end
    want = pending_results.pop_front();
    if (res.slot !== want.slot) report_mismatch("slot", res.slot, want.slot);
    if (res.action !== want.action) report_mismatch("action", res.action, want.action);
    if (res.occupied !== want.occupied) report_mismatch("occupied", res.occupied, want.occupied);
    if (res.frame_total !== want.total) begin
      report_mismatch("frame_total", res.frame_total, want.total);
    end
  endtask

  task automatic queue_frame(logic [28:0] id, logic ext, logic [3:0] len,
                             logic [63:0] data, logic [31:0] now);
    frame_t f;
    f.id = id;
    f.ext = ext;
    f.len = len;
    f.data = data;
    f.now = now;
    rx_frames.push_back(f);
  endtask

  task automatic queue_random(int count);
    logic [28:0] id;
    logic [3:0]  len;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        // small pools mostly hit, large pools keep replacing
        pool_size = $urandom_range(4, 16);
        foreach (id_pool[i]) begin
          id_pool[i] = ($urandom_range(3) == 0) ? 29'($urandom) : 29'($urandom_range(11'h7FF));
        end
      end
      id = ($urandom_range(19) == 0) ? 29'($urandom) : id_pool[$urandom_range(pool_size - 1)];
      len = ($urandom_range(7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
      case ($urandom_range(39))
        0: clock_ms = $urandom;
        1: clock_ms = clock_ms - $urandom_range(1000);
        2, 3: ;
        default: clock_ms = clock_ms + $urandom_range(1, 40);
      endcase
      queue_frame(id, 1'($urandom_range(1)), len, {$urandom, $urandom}, clock_ms);
    end
  endtask

  // frame driver
  always @(posedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
      foreach (tbl_id[i]) begin
        tbl_id[i] = '0;
        tbl_ext[i] = 1'b0;
        tbl_len[i] = '0;
        tbl_data[i] = '0;
        tbl_seen[i] = '0;
      end
      tbl_used = 0;
      frames_seen = '0;
    end else begin
      if (rx.valid && rx.ready) begin
        pending_results.push_back(track_frame(rx_frames.pop_front()));
      end
      if (!rx.valid || rx.ready) begin
        if (rx_frames.size() != 0 && $urandom_range(99) >= snd_idle) begin
          rx.valid <= 1'b1;
          rx.can_id <= rx_frames[0].id;
          rx.is_extended <= rx_frames[0].ext;
          rx.byte_count <= rx_frames[0].len;
          rx.payload <= rx_frames[0].data;
          rx.now_ms <= rx_frames[0].now;
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left = 0;
      last_phase = 0;
    end else begin
      if (res.valid && res.ready) check_result();
      // long hold-off when the no-idle phase starts, to back up the table
      if (phase != last_phase && phase == 2) hold_left = HOLD_CYCLES;
      last_phase = phase;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.can_id = '0;
    rx.is_extended = 1'b0;
    rx.byte_count = '0;
    rx.payload = '0;
    rx.now_ms = '0;
    res.ready = 1'b0;
    phase = 0;
    snd_idle = 11;
    rcv_idle = 57;
    err_count = 0;
    quiet_cycles = 0;
    pool_size = 4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // id 0 on an empty table is a new entry, then a hit with saturated length
    queue_frame(29'h0, 1'b0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    queue_frame(29'h0, 1'b1, 4'd15, 64'h0123_4567_89AB_CDEF, 32'd5);
    queue_frame(29'h1FFF_FFFF, 1'b1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_frame(29'h7FF, 1'b0, 4'd3, 64'hA5A5_A5A5_A5A5_A5A5, 32'd10);
    queue_frame(29'h123, 1'b0, 4'd9, 64'h5A5A_5A5A_5A5A_5A5A, 32'd11);
    queue_frame(29'h456, 1'b1, 4'd1, 64'h1111_2222_3333_4444, 32'd12);
    queue_frame(29'h1AB_CDEF, 1'b1, 4'd7, 64'h8000_0000_0000_0001, 32'd12);
    queue_frame(29'h100, 1'b0, 4'd4, 64'hDEAD_BEEF_CAFE_F00D, 32'd13);
    queue_frame(29'h200, 1'b0, 4'd2, 64'h0F0F_0F0F_0F0F_0F0F, 32'd14);
    // hit on a later entry keeps its extended flag
    queue_frame(29'h7FF, 1'b1, 4'd5, 64'hF0F0_F0F0_F0F0_F0F0, 32'd15);
    // full table, nothing older than now
    queue_frame(29'h300, 1'b0, 4'd6, 64'h1234_5678_9ABC_DEF0, 32'd0);
    queue_frame(29'h301, 1'b0, 4'd8, 64'h0, 32'd20);
    queue_frame(29'h302, 1'b0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    // equal last-seen times, first one goes
    queue_frame(29'h304, 1'b1, 4'd12, 64'h7777_8888_9999_AAAA, 32'd200);
    queue_frame(29'h1FFF_FFFF, 1'b0, 4'd8, 64'h0, 32'hFFFF_FFFF);
    queue_frame(29'h303, 1'b1, 4'd15, 64'hFEDC_BA98_7654_3210, 32'd100);
    queue_frame(29'h303, 1'b0, 4'd0, 64'h0, 32'd101);
    queue_frame(29'h303, 1'b0, 4'd4, 64'hFFFF_FFFF_FFFF_FFFF, 32'd102);
    queue_frame(29'h0AA_AAAA, 1'b1, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    queue_frame(29'h155_5555, 1'b0, 4'd8, 64'h5555_5555_5555_5555, 32'h5555_5555);
    clock_ms = 32'd1000;
    queue_random(625);
    while (rx_frames.size() != 0) @(posedge clk);

    phase = 1;
    snd_idle = 57;
    rcv_idle = 11;
    queue_random(650);
    while (rx_frames.size() != 0) @(posedge clk);

    phase = 2;
    snd_idle = 0;
    rcv_idle = 0;
    queue_random(650);
    while (rx_frames.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
